// ----- rtl/bmp_stream_to_rgb565_defines.svh -----
// Assertion macros shared by the checker.
`ifndef BMP_STREAM_TO_RGB565_DEFINES_SVH
`define BMP_STREAM_TO_RGB565_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define BSR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BSR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check the cycle after reset.
`define BSR_ASSERT_RST(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bsr_pkg.sv -----
package bsr_pkg;

   localparam int POS_W     = 20;
   localparam int MAX_DIM   = 2048;
   localparam int PAL_ENTRIES = 256;
   localparam int PAL_AW    = $clog2(PAL_ENTRIES);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

   localparam logic [15:0] BMP_SIG = 16'h4D42;
   localparam logic [15:0] BPP_8   = 16'd8;
   localparam logic [15:0] BPP_16  = 16'd16;

   localparam logic [POS_W-1:0] HDR_LEN      = 20'd54;
   localparam logic [POS_W:0]   PAL_DATA_START = 21'd1078;
   localparam logic [POS_W-1:0] POS_SIG      = 20'd1;
   localparam logic [POS_W-1:0] POS_SIZE     = 20'd5;
   localparam logic [POS_W-1:0] POS_OFFSET   = 20'd13;
   localparam logic [POS_W-1:0] POS_WIDTH    = 20'd21;
   localparam logic [POS_W-1:0] POS_HEIGHT   = 20'd25;
   localparam logic [POS_W-1:0] POS_DEPTH    = 20'd29;
   localparam logic [POS_W-1:0] POS_HDR_END  = 20'd53;

   localparam logic [19:0] MAX_FILE_RESET = 20'd337920;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SIGNATURE = 3'd1,
      ERR_SIZE      = 3'd2,
      ERR_FORMAT    = 3'd3,
      ERR_TIMEOUT   = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_HEAD = 3'd1,
      PH_PRE  = 3'd2,
      PH_DATA = 3'd3,
      PH_TAIL = 3'd4
   } phase_type;

   typedef enum logic {
      CSR_MAX_FILE_BYTES = 1'b0,
      CSR_IDLE_TIMEOUT   = 1'b1
   } csr_type;

   typedef struct packed {
      logic              wr;
      logic              pix;
      logic              pix8;
      logic              done;
      logic              err;
      err_type           code;
      logic [PAL_AW-1:0] addr;
      logic [23:0]       wr_data;
      logic [15:0]       val16;
      logic [10:0]       frow;
      logic [10:0]       col;
      logic [11:0]       w;
      logic [11:0]       h;
   } entry_type;

   function automatic logic [31:0] magnitude(input logic [31:0] v);
      magnitude = v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

// ----- rtl/bsr_fifo.sv -----
module bsr_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bsr_pkg::entry_type din,
   output logic               full,
   input  logic               pop,
   output bsr_pkg::entry_type dout,
   output logic               empty
);
   import bsr_pkg::*;

   entry_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   assign full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- rtl/bsr_front.sv -----
module bsr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [7:0]         req_data_byte,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [19:0]        csr_data,
   input  logic               fifo_full,
   output logic               push,
   output bsr_pkg::entry_type entry
);
   import bsr_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [10:0]      row_ff, row_in;
   logic [12:0]      rb_ff, rb_in;
   logic [7:0]       low_ff, low_in;
   logic [15:0]      idle_ff, idle_in;
   logic [19:0]      maxf_ff;
   logic [15:0]      timeout_ff;

   logic [31:0]      hword_ff, hword_in;
   logic [19:0]      size_ff, size_in;
   logic [POS_W:0]   start_ff, start_in;
   logic [11:0]      width_ff, width_in;
   logic [11:0]      height_ff, height_in;
   logic             wbig_ff, wbig_in;
   logic             hbig_ff, hbig_in;
   logic             hneg_ff, hneg_in;
   logic             bpp8_ff, bpp8_in;
   logic             bppok_ff, bppok_in;
   logic [7:0]       pal_b_ff, pal_b_in;
   logic [7:0]       pal_g_ff, pal_g_in;

   logic             accept;
   logic             fail;
   logic             drop;
   err_type          code;
   entry_type        ent;
   logic [31:0]      hword_nx;
   logic [31:0]      mag;
   logic [16:0]      tick_nx;
   logic [POS_W:0]   start_sel;
   logic [9:0]       off;
   logic [12:0]      rowsize;
   logic [12:0]      rb_nx;
   logic [11:0]      row_nx;
   phase_type        phase_v;

   assign req_stall = fifo_full;
   assign accept    = req_valid & ~fifo_full;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      row_in    = row_ff;
      rb_in     = rb_ff;
      low_in    = low_ff;
      idle_in   = idle_ff;
      hword_in  = hword_ff;
      size_in   = size_ff;
      start_in  = start_ff;
      width_in  = width_ff;
      height_in = height_ff;
      wbig_in   = wbig_ff;
      hbig_in   = hbig_ff;
      hneg_in   = hneg_ff;
      bpp8_in   = bpp8_ff;
      bppok_in  = bppok_ff;
      pal_b_in  = pal_b_ff;
      pal_g_in  = pal_g_ff;
      fail      = 1'b0;
      drop      = 1'b0;
      code      = ERR_NONE;
      ent       = '0;
      ent.w     = width_ff;
      ent.h     = height_ff;
      hword_nx  = {req_data_byte, hword_ff[31:8]};
      mag       = magnitude(hword_nx);
      tick_nx   = {1'b0, idle_ff} + 17'd1;
      start_sel = bpp8_ff ? PAL_DATA_START : start_ff;
      off       = 10'(pos_ff - HDR_LEN);
      rowsize   = bpp8_ff ? (({1'b0, width_ff} + 13'd3) & ~13'd3)
                          : (({width_ff, 1'b0} + 13'd3) & ~13'd3);
      rb_nx     = rb_ff + 13'd1;
      row_nx    = {1'b0, row_ff} + 12'd1;
      phase_v   = phase_ff;

      if (accept) begin
         if (req_action) begin
            if (phase_ff != PH_IDLE) begin
               if (tick_nx > {1'b0, timeout_ff}) begin
                  fail = 1'b1;
                  code = ERR_TIMEOUT;
               end else begin
                  idle_in = tick_nx[15:0];
               end
            end
         end else begin
            idle_in  = '0;
            hword_in = hword_nx;
            if (phase_ff == PH_IDLE) begin
               phase_v = PH_HEAD;
            end
            if (pos_ff < HDR_LEN) begin
               case (pos_ff)
                  POS_SIG: begin
                     if (hword_nx[31:16] != BMP_SIG) begin
                        fail = 1'b1;
                        code = ERR_SIGNATURE;
                     end
                  end
                  POS_SIZE: begin
                     if ((|hword_nx[31:20]) || (hword_nx[19:0] > maxf_ff)
                         || (hword_nx[19:0] < HDR_LEN)) begin
                        fail = 1'b1;
                        code = ERR_SIZE;
                     end else begin
                        size_in = hword_nx[19:0];
                     end
                  end
                  POS_OFFSET: begin
                     if (|hword_nx[31:POS_W+1]) begin
                        start_in = '1;
                     end else if (hword_nx[POS_W:0] < {1'b0, HDR_LEN}) begin
                        start_in = {1'b0, HDR_LEN};
                     end else begin
                        start_in = hword_nx[POS_W:0];
                     end
                  end
                  POS_WIDTH: begin
                     wbig_in  = (mag > 32'(MAX_DIM));
                     width_in = mag[11:0];
                  end
                  POS_HEIGHT: begin
                     hbig_in   = (mag > 32'(MAX_DIM));
                     height_in = mag[11:0];
                     hneg_in   = req_data_byte[7];
                  end
                  POS_DEPTH: begin
                     bpp8_in  = (hword_nx[31:16] == BPP_8);
                     bppok_in = (hword_nx[31:16] == BPP_8) || (hword_nx[31:16] == BPP_16);
                  end
                  POS_HDR_END: begin
                     if (!bppok_ff || wbig_ff || hbig_ff) begin
                        fail = 1'b1;
                        code = ERR_FORMAT;
                     end else begin
                        phase_v = (width_ff == '0 || height_ff == '0) ? PH_TAIL : PH_PRE;
                     end
                  end
                  default: ;
               endcase
            end else begin
               if (phase_v == PH_PRE) begin
                  if ({1'b0, pos_ff} >= start_sel) begin
                     phase_v = PH_DATA;
                  end else if (bpp8_ff) begin
                     case (off[1:0])
                        2'd0: pal_b_in = req_data_byte;
                        2'd1: pal_g_in = req_data_byte;
                        2'd2: begin
                           ent.wr      = 1'b1;
                           ent.addr    = off[9:2];
                           ent.wr_data = {req_data_byte, pal_g_ff, pal_b_ff};
                        end
                        default: ;
                     endcase
                  end
               end
               if (phase_v == PH_DATA) begin
                  ent.frow  = hneg_ff ? row_ff : (height_ff[10:0] - 11'd1 - row_ff);
                  ent.addr  = req_data_byte;
                  ent.val16 = {low_ff, req_data_byte};
                  if (bpp8_ff) begin
                     if (rb_ff < {1'b0, width_ff}) begin
                        ent.pix  = 1'b1;
                        ent.pix8 = 1'b1;
                        ent.col  = rb_ff[10:0];
                     end
                  end else if (rb_ff < {width_ff, 1'b0}) begin
                     if (!rb_ff[0]) begin
                        low_in = req_data_byte;
                     end else begin
                        ent.pix = 1'b1;
                        ent.col = rb_ff[11:1];
                     end
                  end
                  if (rb_nx >= rowsize) begin
                     rb_in  = '0;
                     row_in = row_nx[10:0];
                     if (row_nx >= height_ff) begin
                        phase_v = PH_TAIL;
                     end
                  end else begin
                     rb_in = rb_nx;
                  end
               end
            end
            phase_in = phase_v;
            pos_in   = pos_ff + 20'd1;
            if (!fail && pos_ff >= POS_HDR_END
                && ({1'b0, pos_ff} + 21'd1) >= {1'b0, size_ff}) begin
               ent.done = 1'b1;
               drop     = 1'b1;
            end
         end
      end

      if (fail) begin
         ent      = '0;
         ent.err  = 1'b1;
         ent.code = code;
         drop     = 1'b1;
      end
      if (drop) begin
         phase_in = PH_IDLE;
         pos_in   = '0;
         row_in   = '0;
         rb_in    = '0;
         low_in   = '0;
         idle_in  = '0;
      end
   end

   assign push  = accept & (ent.wr | ent.pix | ent.done | ent.err);
   assign entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         row_ff   <= '0;
         rb_ff    <= '0;
         low_ff   <= '0;
         idle_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         row_ff   <= row_in;
         rb_ff    <= rb_in;
         low_ff   <= low_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxf_ff    <= MAX_FILE_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_FILE_BYTES: maxf_ff    <= csr_data;
            CSR_IDLE_TIMEOUT:   timeout_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hword_ff  <= hword_in;
      size_ff   <= size_in;
      start_ff  <= start_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      wbig_ff   <= wbig_in;
      hbig_ff   <= hbig_in;
      hneg_ff   <= hneg_in;
      bpp8_ff   <= bpp8_in;
      bppok_ff  <= bppok_in;
      pal_b_ff  <= pal_b_in;
      pal_g_ff  <= pal_g_in;
   end

endmodule

// ----- rtl/bsr_back.sv -----
module bsr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               fifo_empty,
   input  bsr_pkg::entry_type fifo_dout,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [21:0]        rsp_pixel_index,
   output logic [15:0]        rsp_pixel_value,
   output logic [11:0]        rsp_image_width,
   output logic [11:0]        rsp_image_height,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last
);
   import bsr_pkg::*;

   logic [23:0] pal_mem [PAL_ENTRIES];

   logic        s1_v_ff, s1_v_in;
   entry_type   s1_ent_ff;
   logic [23:0] rd_ff;
   logic [21:0] prod_ff;
   logic [22:0] prod_full;

   logic        out_v_ff, out_v_in;
   logic        sent_ff, sent_in;
   logic        o_pix_ff, o_done_ff, o_err_ff;
   err_type     o_code_ff;
   logic [21:0] o_idx_ff;
   logic [15:0] o_val_ff;
   logic [11:0] o_w_ff, o_h_ff;

   logic        final_res;
   logic        out_free;
   logic        s1_ready;
   logic        load;
   logic        show_pix;

   assign show_pix  = o_pix_ff & ~sent_ff;
   assign final_res = o_err_ff | ~(show_pix & o_done_ff);
   assign out_free  = ~out_v_ff | (~rsp_stall & final_res);
   assign s1_ready  = ~s1_v_ff | out_free;
   assign pop       = ~fifo_empty & s1_ready;
   assign load      = s1_v_ff & out_free;
   assign prod_full = fifo_dout.frow * fifo_dout.w;

   always_comb begin
      s1_v_in  = s1_ready ? pop : s1_v_ff;
      out_v_in = out_v_ff;
      sent_in  = sent_ff;
      if (out_free) begin
         out_v_in = load & (s1_ent_ff.pix | s1_ent_ff.done | s1_ent_ff.err);
         sent_in  = 1'b0;
      end else if (out_v_ff && !rsp_stall) begin
         sent_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && fifo_dout.wr) begin
         pal_mem[fifo_dout.addr] <= fifo_dout.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff     <= pal_mem[fifo_dout.addr];
         s1_ent_ff <= fifo_dout;
         prod_ff   <= prod_full[21:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         o_pix_ff  <= s1_ent_ff.pix;
         o_done_ff <= s1_ent_ff.done;
         o_err_ff  <= s1_ent_ff.err;
         o_code_ff <= s1_ent_ff.code;
         o_idx_ff  <= prod_ff + {11'd0, s1_ent_ff.col};
         o_val_ff  <= s1_ent_ff.pix8 ? {rd_ff[23:19], rd_ff[15:10], rd_ff[7:3]}
                                     : s1_ent_ff.val16;
         o_w_ff    <= s1_ent_ff.w;
         o_h_ff    <= s1_ent_ff.h;
      end
   end

   assign rsp_valid = out_v_ff;

   always_comb begin
      rsp_kind         = KIND_DONE;
      rsp_pixel_index  = '0;
      rsp_pixel_value  = '0;
      rsp_image_width  = '0;
      rsp_image_height = '0;
      rsp_error_code   = ERR_NONE;
      rsp_last         = 1'b1;
      if (o_err_ff) begin
         rsp_kind       = KIND_ERROR;
         rsp_error_code = o_code_ff;
      end else if (show_pix) begin
         rsp_kind        = KIND_PIXEL;
         rsp_pixel_index = o_idx_ff;
         rsp_pixel_value = o_val_ff;
         rsp_last        = ~o_done_ff;
      end else begin
         rsp_image_width  = o_w_ff;
         rsp_image_height = o_h_ff;
      end
   end

endmodule

// ----- rtl/bmp_stream_to_rgb565.sv -----
// BMP byte stream to RGB565 pixel decoder.
// Input transactions (req_*) carry either one file byte (req_action 0) or one
// millisecond tick (req_action 1). Each transaction yields zero, one or two
// result transactions (rsp_*): pixel records with their top-down frame index,
// a done record with width and height once the declared file size is reached,
// or an error record when the file is dropped. rsp_last marks the final
// result of one input transaction.
// csr_* writes max_file_bytes (index 0) and idle_timeout_ticks (index 1);
// csr_ready is always high. Write only while the block is idle.
// Throughput: one input transaction per cycle while req_stall is low. A byte
// that produces both a pixel and a done record holds the output until both
// are taken, pixel first. A result passes through the decode queue, then the
// palette read and index multiply, then the output register. req_stall rises
// when the 4-entry decode queue is full; rsp_stall holds the output register
// and backs up the queue. Reset empties the pipeline, drops any partial file
// and restores both registers; palette and header contents are not cleared.
module bmp_stream_to_rgb565 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [21:0] rsp_pixel_index,
   output logic [15:0] rsp_pixel_value,
   output logic [11:0] rsp_image_width,
   output logic [11:0] rsp_image_height,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [19:0] csr_data
);
   import bsr_pkg::*;

   entry_type front_ent;
   entry_type fifo_dout;
   logic      push;
   logic      pop;
   logic      fifo_full;
   logic      fifo_empty;

   assign csr_ready = 1'b1;

   bsr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fifo_full     (fifo_full),
      .push          (push),
      .entry         (front_ent)
   );

   bsr_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_ent),
      .full  (fifo_full),
      .pop   (pop),
      .dout  (fifo_dout),
      .empty (fifo_empty)
   );

   bsr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .fifo_empty       (fifo_empty),
      .fifo_dout        (fifo_dout),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- rtl/bsr_checker.sv -----
`include "bmp_stream_to_rgb565_defines.svh"

module bsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [21:0] rsp_pixel_index,
   input logic [15:0] rsp_pixel_value,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_last
);
   import bsr_pkg::*;

   `BSR_ASSERT_RST(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

   `BSR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_pixel_index) && $stable(rsp_last),
      "stalled result changed")

   `BSR_ASSERT_IMP(a_error_last, clock, reset, rsp_valid && rsp_kind == KIND_ERROR,
      rsp_last && rsp_pixel_index == '0 && rsp_error_code != ERR_NONE,
      "error record malformed")

   `BSR_ASSERT_IMP(a_done_last, clock, reset, rsp_valid && rsp_kind == KIND_DONE,
      rsp_last && rsp_pixel_value == '0 && rsp_error_code == ERR_NONE,
      "done record malformed")

endmodule

bind bmp_stream_to_rgb565 bsr_checker u_bsr_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import bsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic       action;
      logic [7:0] data;
   } stream_item_type;

   typedef struct {
      kind_type    kind;
      logic [21:0] index;
      logic [15:0] value;
      logic [11:0] width;
      logic [11:0] height;
      err_type     code;
      logic        last;
   } pixel_rec_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [21:0] rsp_pixel_index;
   logic [15:0] rsp_pixel_value;
   logic [11:0] rsp_image_width;
   logic [11:0] rsp_image_height;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [19:0] csr_data;

   bmp_stream_to_rgb565 DUT (.*);

   stream_item_type stream_q[$];
   pixel_rec_type   pixel_q[$];
   int mismatches = 0;
   int results_seen = 0;
   int tx_gap = 0;
   int rx_gap = 0;
   int hold_cnt = 0;
   bit hold_done = 0;
   bit steady = 0;
   int idle_cycles = 0;
   int tick_cap = 3;

   // decoder shadow
   logic [19:0] cfg_max_bytes;
   logic [15:0] cfg_timeout;
   logic [19:0] pos_q;
   logic [7:0]  hdr_q[54];
   logic [23:0] pal_q[256];
   logic [31:0] row_q, rbyte_q, iticks_q;
   logic [7:0]  low_q;
   phase_type   phase_q;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] rd16(input int at);
      return {16'd0, hdr_q[at+1], hdr_q[at]};
   endfunction

   function automatic logic [31:0] rd32(input int at);
      return {hdr_q[at+3], hdr_q[at+2], hdr_q[at+1], hdr_q[at]};
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic clear_file();
      phase_q = PH_IDLE;
      pos_q = 0;
      row_q = 0;
      rbyte_q = 0;
      low_q = 0;
      iticks_q = 0;
   endtask

   function automatic pixel_rec_type make_rec(input kind_type k, input logic [31:0] idx,
                                              input logic [31:0] val, input logic [31:0] w,
                                              input logic [31:0] h, input err_type e);
      pixel_rec_type r;
      r.kind = k;
      r.index = idx[21:0];
      r.value = val[15:0];
      r.width = w[11:0];
      r.height = h[11:0];
      r.code = e;
      r.last = 0;
      return r;
   endfunction

   task automatic drop_with(input err_type e);
      pixel_rec_type r;
      clear_file();
      r = make_rec(KIND_ERROR, 0, 0, 0, 0, e);
      r.last = 1;
      pixel_q.push_back(r);
   endtask

   task automatic decode_byte(input logic act, input logic [7:0] b);
      logic [31:0] pos, bpp, w, h, start, off, e, sh, rowsize, rb, col, val, c, frow, t;
      pixel_rec_type outs[$];
      bit emit;
      if (act) begin
         if (phase_q == PH_IDLE) return;
         t = iticks_q + 1;
         if (t > cfg_timeout) begin
            drop_with(ERR_TIMEOUT);
            return;
         end
         iticks_q = t;
         return;
      end
      iticks_q = 0;
      pos = {12'd0, pos_q};
      if (phase_q == PH_IDLE) phase_q = PH_HEAD;
      if (pos < 54) begin
         hdr_q[pos] = b;
         if (pos == 1 && rd16(0) != BMP_SIG) begin
            drop_with(ERR_SIGNATURE);
            return;
         end
         if (pos == 5 && (rd32(2) > cfg_max_bytes || rd32(2) < 54)) begin
            drop_with(ERR_SIZE);
            return;
         end
         if (pos == 53) begin
            bpp = rd16(28);
            w = mag32(rd32(18));
            h = mag32(rd32(22));
            if ((bpp != 8 && bpp != 16) || w > MAX_DIM || h > MAX_DIM) begin
               drop_with(ERR_FORMAT);
               return;
            end
            phase_q = (w == 0 || h == 0) ? PH_TAIL : PH_PRE;
         end
      end else begin
         bpp = rd16(28);
         w = mag32(rd32(18));
         h = mag32(rd32(22));
         if (phase_q == PH_PRE) begin
            if (bpp == 8) start = 1078;
            else begin
               start = rd32(10);
               if (start < 54) start = 54;
            end
            if (pos >= start) phase_q = PH_DATA;
            else if (bpp == 8) begin
               off = pos - 54;
               e = (off >> 2) & 255;
               if ((off & 3) < 3) begin
                  sh = 8 * (off & 3);
                  pal_q[e] = (pal_q[e] & ~(24'hFF << sh)) | (24'(b) << sh);
               end
            end
         end
         if (phase_q == PH_DATA) begin
            rowsize = (bpp == 8) ? ((w + 3) & ~32'd3) : ((2 * w + 3) & ~32'd3);
            rb = rbyte_q;
            emit = 0;
            col = 0;
            val = 0;
            if (bpp == 8) begin
               if (rb < w) begin
                  c = {8'd0, pal_q[b]};
                  val = ((c[23:16] >> 3) << 11) | ((c[15:8] >> 2) << 5) | (c[7:0] >> 3);
                  col = rb;
                  emit = 1;
               end
            end else if (rb < 2 * w) begin
               if (!rb[0]) low_q = b;
               else begin
                  val = {16'd0, low_q, b};
                  col = rb >> 1;
                  emit = 1;
               end
            end
            if (emit) begin
               frow = hdr_q[25][7] ? row_q : (h - 1 - row_q);
               outs.push_back(make_rec(KIND_PIXEL, frow * w + col, val, 0, 0, ERR_NONE));
            end
            rb++;
            if (rb >= rowsize) begin
               rb = 0;
               row_q++;
               if (row_q >= h) phase_q = PH_TAIL;
            end
            rbyte_q = rb;
         end
      end
      pos_q = pos_q + 20'd1;
      if (pos >= 53 && pos + 1 >= rd32(2)) begin
         outs.push_back(make_rec(KIND_DONE, 0, 0, mag32(rd32(18)), mag32(rd32(22)),
                                 ERR_NONE));
         clear_file();
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1;
      foreach (outs[i]) pixel_q.push_back(outs[i]);
   endtask

   // driver
   always @(posedge clock) begin
      stream_item_type it;
      if (reset) begin
         req_valid <= 0;
         req_action <= 0;
         req_data_byte <= 0;
         tx_gap <= 0;
      end else begin
         if (req_valid && !req_stall) decode_byte(req_action, req_data_byte);
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_valid <= 0;
            end else if (stream_q.size() > 0) begin
               it = stream_q.pop_front();
               req_action <= it.action;
               req_data_byte <= it.data;
               req_valid <= 1;
               tx_gap <= pick_gap();
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_rec_type x;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pixel_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result kind=%0d idx=%0d val=%h", rsp_kind,
                           rsp_pixel_index, rsp_pixel_value);
            end else begin
               x = pixel_q.pop_front();
               if (rsp_kind !== x.kind || rsp_pixel_index !== x.index ||
                   rsp_pixel_value !== x.value || rsp_image_width !== x.width ||
                   rsp_image_height !== x.height || rsp_error_code !== x.code ||
                   rsp_last !== x.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp k=%0d i=%0d v=%h w=%0d h=%0d e=%0d l=%0d %s",
                              x.kind, x.index, x.value, x.width, x.height, x.code, x.last,
                              $sformatf("got k=%0d i=%0d v=%h w=%0d h=%0d e=%0d l=%0d",
                                        rsp_kind, rsp_pixel_index, rsp_pixel_value,
                                        rsp_image_width, rsp_image_height,
                                        rsp_error_code, rsp_last));
               end
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_stall <= 1;
         end else if (!hold_done && results_seen >= 8) begin
            hold_done <= 1;
            hold_cnt <= LONG_HOLD;
            rsp_stall <= 1;
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            rx_gap <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_item(input logic act, input logic [7:0] b);
      stream_item_type it;
      it.action = act;
      it.data = b;
      stream_q.push_back(it);
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_item(1, $urandom_range(0, 255));
   endtask

   task automatic push_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < 4) push_ticks($urandom_range(1, tick_cap));
      push_item(0, b);
   endtask

   // sent < 0: send the whole declared size
   task automatic add_file(input logic [15:0] sig, input logic [15:0] bpp, input int w,
                           input int h, input int off, input int adj,
                           input longint force_size, input int sent);
      logic [7:0] hb[54];
      int mw, mh, start, rowsize, n;
      logic [31:0] size;
      mw = w < 0 ? -w : w;
      mh = h < 0 ? -h : h;
      start = (bpp == BPP_8) ? 1078 : (off < 54 ? 54 : off);
      rowsize = (bpp == BPP_8) ? ((mw + 3) & ~3) : ((2 * mw + 3) & ~3);
      size = (force_size >= 0) ? force_size[31:0] : 32'(start + rowsize * mh + adj);
      foreach (hb[i]) hb[i] = $urandom_range(0, 255);
      {hb[1], hb[0]} = sig;
      {hb[5], hb[4], hb[3], hb[2]} = size;
      {hb[13], hb[12], hb[11], hb[10]} = 32'(off);
      {hb[21], hb[20], hb[19], hb[18]} = 32'(w);
      {hb[25], hb[24], hb[23], hb[22]} = 32'(h);
      {hb[29], hb[28]} = bpp;
      n = (sent >= 0) ? sent : int'(size);
      for (int i = 0; i < n; i++)
         push_byte(i < 54 ? hb[i] : 8'($urandom_range(0, 255)));
   endtask

   task automatic write_reg(input csr_type idx, input logic [19:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_MAX_FILE_BYTES) cfg_max_bytes = val;
      else cfg_timeout = val[15:0];
   endtask

   task automatic drain();
      wait (stream_q.size() == 0 && !req_valid && pixel_q.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic random_item();
      int r, bp, w, h;
      r = $urandom_range(0, 99);
      bp = 16;
      w = $urandom_range(0, 6);
      h = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) w = -w;
      if ($urandom_range(0, 1) == 0) h = -h;
      if (r < 68) begin
         add_file(BMP_SIG, bp, w, h, $urandom_range(0, 70), $urandom_range(0, 4) - 1, -1, -1);
      end else if (r < 80) begin
         case ($urandom_range(0, 3))
            0: add_file($urandom_range(0, 65535), 16, w, h, 54, 0, -1, 2);
            1: add_file(BMP_SIG, 16, w, h, 54, 0, cfg_max_bytes + $urandom_range(1, 1 << 24),
                        6);
            2: add_file(BMP_SIG, $urandom_range(0, 65535), w, h, 54, 0, -1, 54);
            default: add_file(BMP_SIG, 16, 2049 + $urandom_range(0, 100), h, 54, 0, -1, 54);
         endcase
      end else if (r < 90) begin
         add_file(BMP_SIG, 16, w, h, 54, 0, -1, $urandom_range(2, 60));
         if (cfg_timeout <= 50) push_ticks(cfg_timeout + 1);
         else add_file(16'h0000, 16, 0, 0, 54, 0, -1, 2);
      end else begin
         repeat ($urandom_range(1, 5)) push_byte($urandom_range(0, 255));
         push_ticks($urandom_range(0, 3));
         if (cfg_timeout <= 50) push_ticks(cfg_timeout + 1);
      end
   endtask

   initial begin
      reset = 1;
      csr_valid = 0;
      csr_index = CSR_MAX_FILE_BYTES;
      csr_data = 0;
      cfg_max_bytes = MAX_FILE_RESET;
      cfg_timeout = TIMEOUT_RESET;
      foreach (hdr_q[i]) hdr_q[i] = 0;
      foreach (pal_q[i]) pal_q[i] = 0;
      clear_file();
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed cases at reset settings
      push_ticks(3);
      add_file(BMP_SIG, 16, 2, 2, 54, 0, -1, -1);
      add_file(BMP_SIG, 16, -3, -2, 60, 0, -1, -1);
      add_file(BMP_SIG, 16, 2, 2, 54, 0, 53, 6);
      add_file(BMP_SIG, 8, 5, 2, 0, 7, -1, -1);
      add_file(BMP_SIG, 16, 3, 3, 54, -5, -1, -1);
      add_file(BMP_SIG, 16, 1, 1, 10, 3, -1, -1);
      add_file(BMP_SIG, 16, 2048, 1, 54, 0, 60, -1);
      add_file(BMP_SIG, 16, 1, -2048, 54, 0, 62, -1);
      push_ticks(5);
      drain();

      write_reg(CSR_MAX_FILE_BYTES, 20'd54);
      write_reg(CSR_IDLE_TIMEOUT, 20'd1);
      tick_cap = 1;
      add_file(BMP_SIG, 16, 0, 0, 54, 0, -1, -1);
      add_file(BMP_SIG, 16, 0, 1, 54, 1, -1, 6);
      add_file(BMP_SIG, 16, 0, 0, 54, 0, -1, 10);
      push_ticks(2);
      add_file(BMP_SIG, 16, 0, 0, 54, 0, -1, 30);
      push_ticks(1);
      add_file(BMP_SIG, 16, 0, 0, 54, 0, -1, 54);
      drain();

      write_reg(CSR_MAX_FILE_BYTES, 20'hFFFFF);
      write_reg(CSR_IDLE_TIMEOUT, 20'hFFFF);
      tick_cap = 3;
      steady = 1;
      add_file(BMP_SIG, 16, 5, 4, 54, 0, -1, -1);
      add_file(BMP_SIG, 16, 1, 1, 54, 0, 20'hFFFFF, 20);
      add_file(16'h0000, 16, 0, 0, 54, 0, -1, 2);
      steady = 0;
      while (stream_q.size() < 60) random_item();
      drain();

      write_reg(CSR_MAX_FILE_BYTES, 20'($urandom_range(54, 400)));
      write_reg(CSR_IDLE_TIMEOUT, 20'($urandom_range(2, 8)));
      tick_cap = 2;
      while (stream_q.size() < 60) random_item();
      drain();

      write_reg(CSR_MAX_FILE_BYTES, MAX_FILE_RESET);
      write_reg(CSR_IDLE_TIMEOUT, 20'(TIMEOUT_RESET));
      tick_cap = 3;
      while (stream_q.size() < 60) random_item();
      drain();

      if (mismatches == 0 && pixel_q.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
